>>> src/swrs_pkg.sv
// ----------------------------------------------------------------------------
// swrs_pkg
// Shared types and constants of the service watchdog restart supervisor.
// ----------------------------------------------------------------------------
package swrs_pkg;

   localparam int SLOT_COUNT_DEF = 8;
   localparam int SLOT_FIELD_W = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [12:0] BACKOFF_BASE_MS = 13'd1000;
   localparam logic [12:0] BACKOFF_CAP_MS = 13'd8000;
   localparam logic [7:0] ON_CRASH_LIMIT = 8'd3;
   localparam logic [7:0] CRASH_MAX = 8'hFF;
   localparam logic [17:0] MS_PER_S = 18'd1000;
   localparam logic [31:0] DUE_WINDOW = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      OP_LAUNCH = 2'd0,
      OP_BEAT = 2'd1,
      OP_POLL = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ACT_STARTED = 3'd0,
      ACT_RESTART = 3'd1,
      ACT_RETIRE = 3'd2,
      ACT_REBOOT = 3'd3,
      ACT_UNKNOWN = 3'd4
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SERVICE_ENABLE = 2'd0,
      CSR_RESTART_MODES = 2'd1,
      CSR_ESSENTIAL_MASK = 2'd2,
      CSR_HEARTBEAT_TIMEOUTS = 2'd3
   } csr_index_type;

   localparam logic [1:0] MODE_ALWAYS = 2'd0;
   localparam logic [1:0] MODE_ON_CRASH = 2'd1;

   typedef struct packed {
      logic load;
      logic step;
      logic flush;
      logic [SLOT_FIELD_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic halted;
   } stat_type;

endpackage

>>> src/swrs_ctrl.sv
// ----------------------------------------------------------------------------
// swrs_ctrl
// Sequencer: accepts a request, walks the slots one per cycle unless stalled
// (a heartbeat is a single step), flushes the held result with its last mark.
// ----------------------------------------------------------------------------
module swrs_ctrl import swrs_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_op,
   output logic       req_stall,
   input  stat_type   stat,
   output cmd_type    cmd
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_BEAT,
      S_FLUSH
   } state_type;

   state_type         state_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic              req_stall_ff;
   logic              accept;

   assign req_stall = req_stall_ff;
   assign accept = req_valid && !req_stall_ff;

   always_comb begin
      cmd.load = accept;
      cmd.step = 1'b0;
      cmd.flush = 1'b0;
      cmd.idx = SLOT_FIELD_W'(idx_ff);
      unique case (state_ff)
         S_IDLE: begin
         end
         S_WALK: begin
            cmd.step = stat.out_free && !stat.halted;
         end
         S_BEAT: begin
            cmd.step = stat.out_free;
         end
         S_FLUSH: begin
            cmd.flush = stat.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         req_stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept && !stat.halted) begin
                  unique case (op_type'(req_op)) inside
                     OP_LAUNCH, OP_POLL: begin
                        state_ff <= S_WALK;
                        idx_ff <= '0;
                        req_stall_ff <= 1'b1;
                     end
                     OP_BEAT: begin
                        state_ff <= S_BEAT;
                        req_stall_ff <= 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_WALK: begin
               if (stat.halted) begin
                  state_ff <= S_FLUSH;
               end else if (stat.out_free) begin
                  if (idx_ff == LAST_SLOT) begin
                     state_ff <= S_FLUSH;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            S_BEAT: begin
               if (stat.out_free) begin
                  state_ff <= S_FLUSH;
               end
            end
            S_FLUSH: begin
               if (stat.out_free) begin
                  state_ff <= S_IDLE;
                  req_stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

>>> src/swrs_dp.sv
// ----------------------------------------------------------------------------
// swrs_dp
// Datapath: configuration registers, per-slot supervision state, the slot
// evaluation unit, the held result and the response register.
// ----------------------------------------------------------------------------
module swrs_dp import swrs_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic [1:0]              req_op,
   input  logic [SLOT_FIELD_W-1:0] req_slot,
   input  logic [31:0]             req_now_ms,
   input  logic [7:0]              req_alive_mask,
   input  cmd_type                 cmd,
   output stat_type                stat,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_action,
   output logic [2:0]              rsp_slot_index,
   output logic [7:0]              rsp_crash_total,
   output logic [12:0]             rsp_retry_delay,
   output logic                    rsp_last
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   logic [7:0]  enable_ff;
   logic [15:0] modes_ff;
   logic [7:0]  essential_ff;
   logic [63:0] timeouts_ff;

   op_type                  op_ff;
   logic [SLOT_FIELD_W-1:0] slot_ff;
   logic [31:0]             now_ff;
   logic [7:0]              alive_ff;

   logic [SLOT_COUNT-1:0] in_service_ff, in_service_in;
   logic [SLOT_COUNT-1:0] has_task_ff, has_task_in;
   logic [SLOT_COUNT-1:0] restart_wait_ff, restart_wait_in;
   logic [SLOT_COUNT-1:0] beat_seen_ff, beat_seen_in;
   logic                  halted_ff, halted_in;
   logic [7:0]            crashes_ff [SLOT_COUNT];
   logic [31:0]           restart_time_ff [SLOT_COUNT];
   logic [31:0]           last_beat_ff [SLOT_COUNT];

   logic        pend_valid_ff, pend_valid_in;
   action_type  pend_action_ff, pend_action_in;
   logic [2:0]  pend_slot_ff, pend_slot_in;
   logic [7:0]  pend_crash_ff, pend_crash_in;
   logic [12:0] pend_back_ff, pend_back_in;

   logic        rsp_valid_ff, rsp_valid_in;
   action_type  rsp_action_ff, rsp_action_in;
   logic [2:0]  rsp_slot_ff, rsp_slot_in;
   logic [7:0]  rsp_crash_ff, rsp_crash_in;
   logic [12:0] rsp_back_ff, rsp_back_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [SLOT_W-1:0] i;
   logic [SLOT_W-1:0] beat_idx;
   logic              beat_known;
   logic [7:0]        tmo;
   logic [17:0]       limit_ms;
   logic              expired;
   logic              due;
   logic              slot_ok;
   logic              refresh;
   logic [7:0]        crash_cur;
   logic [7:0]        crash_inc;
   logic [1:0]        mode;
   logic              again;
   logic [12:0]       back;
   logic              out_free;

   logic        crash_wr, lb_wr, rt_wr;
   logic [7:0]  crash_wdata;
   logic        res_valid;
   action_type  res_action;
   logic [2:0]  res_slot;
   logic [7:0]  res_crash;
   logic [12:0] res_back;

   assign i = cmd.idx[SLOT_W-1:0];
   assign beat_idx = slot_ff[SLOT_W-1:0];
   assign beat_known = (32'(slot_ff) < 32'(SLOT_COUNT)) && in_service_ff[beat_idx];

   assign tmo = timeouts_ff[{i, 3'b000} +: 8];
   assign limit_ms = 18'(tmo) * MS_PER_S;
   assign expired = (now_ff - last_beat_ff[i]) >= 32'(limit_ms);
   assign due = (now_ff - restart_time_ff[i]) < DUE_WINDOW;
   assign slot_ok = has_task_ff[i] && alive_ff[i]
                    && ((tmo == 8'd0) || beat_seen_ff[i] || !expired);
   assign refresh = has_task_ff[i] && alive_ff[i] && (tmo != 8'd0) && beat_seen_ff[i];

   assign crash_cur = crashes_ff[i];
   assign crash_inc = (crash_cur == CRASH_MAX) ? crash_cur : crash_cur + 8'd1;
   assign mode = modes_ff[{i, 1'b0} +: 2];
   assign again = (mode == MODE_ALWAYS) || ((mode == MODE_ON_CRASH) && (crash_inc <= ON_CRASH_LIMIT));
   assign back = (crash_inc <= ON_CRASH_LIMIT)
                 ? 13'(BACKOFF_BASE_MS << 2'(crash_inc - 8'd1)) : BACKOFF_CAP_MS;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign stat.out_free = out_free;
   assign stat.halted = halted_ff;

   always_comb begin
      in_service_in = in_service_ff;
      has_task_in = has_task_ff;
      restart_wait_in = restart_wait_ff;
      beat_seen_in = beat_seen_ff;
      halted_in = halted_ff;
      crash_wr = 1'b0;
      crash_wdata = 8'd0;
      lb_wr = 1'b0;
      rt_wr = 1'b0;
      res_valid = 1'b0;
      res_action = ACT_STARTED;
      res_slot = cmd.idx;
      res_crash = 8'd0;
      res_back = 13'd0;
      if (cmd.step) begin
         unique case (op_ff)
            OP_LAUNCH: begin
               if (enable_ff[i]) begin
                  in_service_in[i] = 1'b1;
                  has_task_in[i] = 1'b1;
                  restart_wait_in[i] = 1'b0;
                  beat_seen_in[i] = 1'b0;
                  crash_wr = 1'b1;
                  lb_wr = 1'b1;
                  res_valid = 1'b1;
               end
            end
            OP_BEAT: begin
               if (beat_known) begin
                  beat_seen_in[beat_idx] = 1'b1;
               end else begin
                  res_valid = 1'b1;
                  res_action = ACT_UNKNOWN;
                  res_slot = slot_ff;
               end
            end
            OP_POLL: begin
               if (in_service_ff[i]) begin
                  if (restart_wait_ff[i]) begin
                     if (due) begin
                        has_task_in[i] = 1'b1;
                        restart_wait_in[i] = 1'b0;
                        beat_seen_in[i] = 1'b0;
                        lb_wr = 1'b1;
                        res_valid = 1'b1;
                        res_crash = crash_cur;
                     end
                  end else if (slot_ok) begin
                     if (refresh) begin
                        beat_seen_in[i] = 1'b0;
                        lb_wr = 1'b1;
                     end
                  end else begin
                     crash_wr = 1'b1;
                     crash_wdata = crash_inc;
                     has_task_in[i] = 1'b0;
                     res_valid = 1'b1;
                     res_crash = crash_inc;
                     if (again) begin
                        rt_wr = 1'b1;
                        restart_wait_in[i] = 1'b1;
                        res_action = ACT_RESTART;
                        res_back = back;
                     end else if (essential_ff[i]) begin
                        halted_in = 1'b1;
                        res_action = ACT_REBOOT;
                     end else begin
                        in_service_in[i] = 1'b0;
                        beat_seen_in[i] = 1'b0;
                        crash_wdata = 8'd0;
                        res_action = ACT_RETIRE;
                        res_crash = 8'd0;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_action_in = pend_action_ff;
      pend_slot_in = pend_slot_ff;
      pend_crash_in = pend_crash_ff;
      pend_back_in = pend_back_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_action_in = rsp_action_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_crash_in = rsp_crash_ff;
      rsp_back_in = rsp_back_ff;
      rsp_last_in = rsp_last_ff;
      if ((res_valid && pend_valid_ff) || (cmd.flush && pend_valid_ff)) begin
         rsp_valid_in = 1'b1;
         rsp_action_in = pend_action_ff;
         rsp_slot_in = pend_slot_ff;
         rsp_crash_in = pend_crash_ff;
         rsp_back_in = pend_back_ff;
         rsp_last_in = cmd.flush;
      end
      if (res_valid) begin
         pend_valid_in = 1'b1;
         pend_action_in = res_action;
         pend_slot_in = res_slot;
         pend_crash_in = res_crash;
         pend_back_in = res_back;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         modes_ff <= '0;
         essential_ff <= '0;
         timeouts_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_SERVICE_ENABLE: enable_ff <= csr_wdata[7:0];
            CSR_RESTART_MODES: modes_ff <= csr_wdata[15:0];
            CSR_ESSENTIAL_MASK: essential_ff <= csr_wdata[7:0];
            CSR_HEARTBEAT_TIMEOUTS: timeouts_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_service_ff <= '0;
         has_task_ff <= '0;
         restart_wait_ff <= '0;
         beat_seen_ff <= '0;
         halted_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < SLOT_COUNT; k++) begin
            crashes_ff[k] <= 8'd0;
         end
      end else begin
         in_service_ff <= in_service_in;
         has_task_ff <= has_task_in;
         restart_wait_ff <= restart_wait_in;
         beat_seen_ff <= beat_seen_in;
         halted_ff <= halted_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (crash_wr) begin
            crashes_ff[i] <= crash_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= op_type'(req_op);
         slot_ff <= req_slot;
         now_ff <= req_now_ms;
         alive_ff <= req_alive_mask;
      end
      if (lb_wr) begin
         last_beat_ff[i] <= now_ff;
      end
      if (rt_wr) begin
         restart_time_ff[i] <= now_ff + 32'(back);
      end
      pend_action_ff <= pend_action_in;
      pend_slot_ff <= pend_slot_in;
      pend_crash_ff <= pend_crash_in;
      pend_back_ff <= pend_back_in;
      rsp_action_ff <= rsp_action_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_crash_ff <= rsp_crash_in;
      rsp_back_ff <= rsp_back_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_action = rsp_action_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_crash_total = rsp_crash_ff;
   assign rsp_retry_delay = rsp_back_ff;
   assign rsp_last = rsp_last_ff;

endmodule

>>> src/service_watchdog_restart_supervisor_unit.sv
// ----------------------------------------------------------------------------
// service_watchdog_restart_supervisor_unit
// Multi-slot service watchdog with exponential backoff restart.
// ----------------------------------------------------------------------------
// One request is handled at a time. A launch or poll request walks the slots
// through a single shared slot evaluation unit, one slot per cycle, and
// req_stall holds off the next request until the walk and the flush are
// done, as it does for a heartbeat. Each result is held until the next result
// or the flush so that the last mark can be set, and the walk pauses while
// rsp_stall holds a full response register. After a reboot request every
// later request is accepted and dropped until reset.
module service_watchdog_restart_supervisor_unit import swrs_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_op,
   input  logic [SLOT_FIELD_W-1:0] req_slot,
   input  logic [31:0]             req_now_ms,
   input  logic [7:0]              req_alive_mask,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_action,
   output logic [2:0]              rsp_slot_index,
   output logic [7:0]              rsp_crash_total,
   output logic [12:0]             rsp_retry_delay,
   output logic                    rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   swrs_ctrl #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   swrs_dp #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_op          (req_op),
      .req_slot        (req_slot),
      .req_now_ms      (req_now_ms),
      .req_alive_mask  (req_alive_mask),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_action      (rsp_action),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_crash_total (rsp_crash_total),
      .rsp_retry_delay (rsp_retry_delay),
      .rsp_last        (rsp_last)
   );

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !stat.halted
       && (req_op == OP_LAUNCH || req_op == OP_BEAT || req_op == OP_POLL)) |=> req_stall)
      else $error("request accepted without entering the walk");

   a_reboot_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action == ACT_REBOOT) |-> rsp_last)
      else $error("reboot request not the final response");

   a_backoff_only_on_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_action != ACT_RESTART) |-> (rsp_retry_delay == 13'd0))
      else $error("backoff reported on a non-restart response");

endmodule
